// ===== rtl/set_assoc_lru_cache_unit_macros.svh =====
// assertion macros for the cache tag unit checker
// no dependencies; included by files that carry concurrent assertions
`ifndef SET_ASSOC_LRU_CACHE_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SALC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cache unit check failed");

// next-cycle implication, disabled while reset is asserted
`define SALC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cache unit check failed");

`endif

// ===== rtl/salc_pkg.sv =====
// shared types and constants for the set-associative lru cache tag unit
// no dependencies
package salc_pkg;

	localparam int MAX_WAYS_DEF  = 8;
	localparam int MAX_SETS_DEF  = 1024;
	localparam int ADDR_BITS_DEF = 32;

	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

	localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
	localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd6;
	localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd4;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_STORE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] way;
		logic       writeback;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic        dirty;
		logic [31:0] tag;
		logic [31:0] stamp;
	} line_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

endpackage

// ===== rtl/salc_decode.sv =====
// address split into set and tag, and effective way count, from the config
// depends on salc_pkg
module salc_decode import salc_pkg::*; #(
	parameter int MAX_WAYS  = MAX_WAYS_DEF,
	parameter int MAX_SETS  = MAX_SETS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	localparam int MAX_IB   = $clog2(MAX_SETS + 1) - 1,
	localparam int SET_W    = (MAX_IB > 0) ? MAX_IB : 1,
	localparam int CNT_W    = $clog2(MAX_WAYS + 1)
) (
	input  logic [CFG_W-1:0] offset_bits,
	input  logic [CFG_W-1:0] index_bits,
	input  logic [CFG_W-1:0] ways_in_use,
	input  logic [31:0]      address,
	output logic [SET_W-1:0] set,
	output logic [31:0]      tag,
	output logic [CNT_W-1:0] nways
);

	localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ADDR_BITS) - 64'd1);

	logic [CFG_W:0] ib_ext;
	logic [CFG_W:0] eff_ib;
	logic [CFG_W:0] w_ext;
	logic [31:0]    block;
	logic [31:0]    set_full;

	always_comb begin
		// index bits are capped so the set count never exceeds the table
		ib_ext = {1'b0, index_bits};
		eff_ib = (ib_ext > (CFG_W+1)'(MAX_IB)) ? (CFG_W+1)'(MAX_IB) : ib_ext;
		block = (address & ADDR_MASK) >> offset_bits;
		set_full = block & ~(32'hFFFF_FFFF << eff_ib);
		set = SET_W'(set_full);
		tag = block >> eff_ib;
	end

	always_comb begin
		w_ext = {1'b0, ways_in_use};
		if (w_ext == '0) begin
			nways = CNT_W'(1);
		end else if (w_ext > (CFG_W+1)'(MAX_WAYS)) begin
			nways = CNT_W'(MAX_WAYS);
		end else begin
			nways = CNT_W'(w_ext);
		end
	end

endmodule

// ===== rtl/set_assoc_lru_cache_unit.sv =====
// each word is scanned over k ways before its result leaves, k = ways scanned (hit at
// way h scans h + 1 ways, a miss scans every way in use); no new word is taken
// until the result is committed, and the commit waits while a held result is stalled
// the set row is read once, then the ways are compared one per cycle by the scan loop
// reset: after arst_n releases, a clearing pass over every set row
// zeroes the set memory; no word is taken until it ends
module set_assoc_lru_cache_unit import salc_pkg::*; #(
	parameter int MAX_WAYS  = MAX_WAYS_DEF,
	parameter int MAX_SETS  = MAX_SETS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  req_t                 in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsp_t                 out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W    = $clog2(MAX_WAYS + 1);
	localparam int MAX_IB   = $clog2(MAX_SETS + 1) - 1;
	localparam int SET_W    = (MAX_IB > 0) ? MAX_IB : 1;
	localparam int SET_ROWS = 1 << MAX_IB;
	localparam logic [SET_W-1:0] LAST_ROW = SET_W'(SET_ROWS - 1);

	typedef line_t [MAX_WAYS-1:0] row_t;

	// config
	logic [CFG_W-1:0] offset_bits_q;
	logic [CFG_W-1:0] index_bits_q;
	logic [CFG_W-1:0] ways_in_use_q;

	// control
	state_t           state_q, state_d;
	logic [SET_W-1:0] clr_cnt_q;
	logic [31:0]      clock_q;
	logic             out_valid_q;
	rsp_t             out_word_q;
	logic             in_acc;
	logic             out_free;
	logic             commit;
	logic             mem_we;
	logic             clearing;
	logic             scan_en;

	// decode
	logic [SET_W-1:0] dec_set;
	logic [31:0]      dec_tag;
	logic [CNT_W-1:0] nways;

	// per-access state
	logic             action_q;
	logic [SET_W-1:0] set_q;
	logic [31:0]      tag_q;
	row_t             rd_row_s1;
	logic [WAY_W-1:0] way_cnt_q;
	logic             hit_q;
	logic [WAY_W-1:0] hit_way_q;
	logic             free_found_q;
	logic [WAY_W-1:0] free_way_q;
	logic [WAY_W-1:0] victim_q;
	logic [31:0]      best_age_q;

	// scan datapath
	line_t            cur;
	logic             line_hit;
	logic [31:0]      age;
	logic             scan_last;

	// write-back datapath
	logic [WAY_W-1:0] fin_way;
	logic             wb;
	row_t             new_row;
	row_t             wr_row;
	logic [SET_W-1:0] wr_addr;
	rsp_t             rsp_d;

	row_t             row_mem_q [SET_ROWS];

	salc_decode #(
		.MAX_WAYS  (MAX_WAYS),
		.MAX_SETS  (MAX_SETS),
		.ADDR_BITS (ADDR_BITS)
	) u_decode (
		.offset_bits (offset_bits_q),
		.index_bits  (index_bits_q),
		.ways_in_use (ways_in_use_q),
		.address     (in_word.address),
		.set         (dec_set),
		.tag         (dec_tag),
		.nways       (nways)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_ROW) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (line_hit || scan_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// fsm outputs
	always_comb begin
		in_stall = 1'b1;
		clearing = 1'b0;
		scan_en  = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_IDLE:  in_stall = 1'b0;
			ST_SCAN:  scan_en  = 1'b1;
			ST_WRITE: commit   = out_free;
			default:  clearing = 1'b0;
		endcase
		mem_we = clearing || commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + SET_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_BITS_RST;
			index_bits_q  <= INDEX_BITS_RST;
			ways_in_use_q <= WAYS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				REG_INDEX_BITS:  index_bits_q  <= cfg_data;
				REG_WAYS_IN_USE: ways_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan of one way per cycle
	always_comb begin
		cur       = rd_row_s1[way_cnt_q];
		line_hit  = scan_en && cur.valid && (cur.tag == tag_q);
		age       = clock_q - cur.stamp;
		scan_last = (CNT_W'(way_cnt_q) + CNT_W'(1)) == nways;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_cnt_q    <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (in_acc) begin
			way_cnt_q    <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (scan_en) begin
			way_cnt_q <= way_cnt_q + WAY_W'(1);
			if (line_hit) begin
				hit_q <= 1'b1;
			end
			if (!cur.valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q <= in_word.action;
			set_q    <= dec_set;
			tag_q    <= dec_tag;
		end
		if (scan_en) begin
			if (line_hit) begin
				hit_way_q <= way_cnt_q;
			end
			if (!cur.valid && !free_found_q) begin
				free_way_q <= way_cnt_q;
			end
			// strict compare keeps the lowest way on a tie
			if (way_cnt_q == '0 || age > best_age_q) begin
				best_age_q <= age;
				victim_q   <= way_cnt_q;
			end
		end
	end

	// row update and result
	always_comb begin
		if (hit_q) begin
			fin_way = hit_way_q;
		end else if (free_found_q) begin
			fin_way = free_way_q;
		end else begin
			fin_way = victim_q;
		end
		wb = !hit_q && !free_found_q && rd_row_s1[victim_q].dirty;

		new_row = rd_row_s1;
		new_row[fin_way].stamp = clock_q;
		if (hit_q) begin
			new_row[fin_way].dirty = rd_row_s1[fin_way].dirty || (action_q == ACT_STORE);
		end else begin
			new_row[fin_way].valid = 1'b1;
			new_row[fin_way].tag   = tag_q;
			new_row[fin_way].dirty = (action_q == ACT_STORE);
		end

		wr_row  = clearing ? row_t'('0) : new_row;
		wr_addr = clearing ? clr_cnt_q : set_q;

		rsp_d.hit       = hit_q;
		rsp_d.way       = 3'(fin_way);
		rsp_d.writeback = wb;
	end

	// set memory; a read only happens in idle, never on the edge of a write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem_q[wr_addr] <= wr_row;
		end
		if (in_acc) begin
			rd_row_s1 <= row_mem_q[dec_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				clock_q     <= clock_q + 32'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_word_q <= rsp_d;
		end
	end

endmodule

// ===== rtl/salc_checker.sv =====
// port-level checks for the cache tag unit, bound to the top level
// depends on salc_pkg and set_assoc_lru_cache_unit_macros.svh
`include "set_assoc_lru_cache_unit_macros.svh"

module salc_checker import salc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_word
);

	// a held result word does not change
	`SALC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word))

	// one access in flight: the input is stalled right after a word is taken
	`SALC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// a hit never evicts
	`SALC_ASSERT_IMPL(a_hit_no_wb, clk, arst_n, out_valid && out_word.hit, !out_word.writeback)

	// a new result comes only out of the busy phase
	`SALC_ASSERT_IMPL(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind set_assoc_lru_cache_unit salc_checker u_salc_checker (.*);
